// ----- rtl/core/square_tone_channel_unit_defines.svh -----
// Assertion macros for the file that checks its own logic.
`ifndef SQUARE_TONE_CHANNEL_UNIT_DEFINES_SVH
`define SQUARE_TONE_CHANNEL_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/sts_pkg.sv -----
package sts_pkg;

   localparam int unsigned NUM_REGS = 5;

   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   localparam logic [2:0] REG_SWEEP    = 3'd0;
   localparam logic [2:0] REG_LENGTH   = 3'd1;
   localparam logic [2:0] REG_ENVELOPE = 3'd2;
   localparam logic [2:0] REG_FREQ_LO  = 3'd3;
   localparam logic [2:0] REG_FREQ_HI  = 3'd4;

   localparam logic [15:0] TICK_RATE     = 16'd44100;
   localparam logic [9:0]  AMPLITUDE     = 10'd600;
   localparam logic [11:0] FREQ_BASE     = 12'd2048;
   localparam logic [3:0]  VOLUME_MAX    = 4'd15;
   localparam logic [15:0] QUOTIENT_MAX  = 16'hFFFF;
   localparam int unsigned STEP_NUMERATOR = 1048576;
   localparam logic [15:0] FREQ_REM_INIT = 16'(STEP_NUMERATOR >> 16);
   localparam logic [11:0] CLAMP_DIVISOR = 12'(STEP_NUMERATOR / (int'(QUOTIENT_MAX) + 1));
   localparam logic [4:0]  FREQ_STEPS    = 5'd16;
   localparam logic [4:0]  RATE_STEPS    = 5'd17;

   typedef enum logic [1:0] {
      STEP_IDLE,
      STEP_FREQ,
      STEP_RATE,
      STEP_DONE
   } sts_step_state_type;

   typedef struct packed {
      logic        start;
      logic [11:0] divisor;
   } sts_step_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [16:0] step;
   } sts_step_rsp_type;

   function automatic logic duty_bit(logic [1:0] duty, logic [2:0] pos);
      logic [7:0] pattern;
      case (duty)
         2'd0:    pattern = 8'h01;
         2'd1:    pattern = 8'h03;
         2'd2:    pattern = 8'h0F;
         default: pattern = 8'h3F;
      endcase
      return pattern[pos];
   endfunction

   function automatic logic [11:0] sweep_period_of(logic [2:0] sweep_sel);
      logic [18:0] prod;
      prod = 19'(sweep_sel) * 19'(TICK_RATE);
      return 12'(prod >> 7);
   endfunction

   function automatic logic [13:0] length_time_of(logic [5:0] length);
      logic [6:0]  remaining;
      logic [21:0] prod;
      remaining = 7'd64 - 7'(length);
      prod = 22'(remaining) * 22'(TICK_RATE);
      return 14'(prod >> 8);
   endfunction

   function automatic logic [12:0] env_time_of(logic [2:0] period);
      logic [18:0] prod;
      prod = 19'(period) * 19'(TICK_RATE);
      return 13'(prod >> 6);
   endfunction

endpackage

// ----- rtl/core/sts_step_unit.sv -----
module sts_step_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  sts_pkg::sts_step_req_type step_req,
   output sts_pkg::sts_step_rsp_type step_rsp
);
   import sts_pkg::*;

   sts_step_state_type state_ff, state_in;
   logic [15:0] rem_ff, rem_in;
   logic [16:0] dvd_ff, dvd_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;
   logic [15:0] rem_step;
   logic [16:0] dvd_step;

   // One restoring division bit per cycle; the quotient shifts into the dividend register.
   always_comb begin
      trial    = {rem_ff, dvd_ff[16]};
      diff     = trial - {1'b0, dsr_ff};
      fits     = trial >= {1'b0, dsr_ff};
      rem_step = fits ? diff[15:0] : trial[15:0];
      dvd_step = {dvd_ff[15:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STEP_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      dsr_in   = dsr_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         STEP_IDLE: begin
            if (step_req.start) begin
               if (step_req.divisor <= CLAMP_DIVISOR) begin
                  rem_in   = {1'b0, QUOTIENT_MAX[15:1]};
                  dvd_in   = {QUOTIENT_MAX[0], 16'b0};
                  dsr_in   = TICK_RATE;
                  cnt_in   = RATE_STEPS - 5'd1;
                  state_in = STEP_RATE;
               end else begin
                  rem_in   = FREQ_REM_INIT;
                  dvd_in   = '0;
                  dsr_in   = {4'b0, step_req.divisor};
                  cnt_in   = FREQ_STEPS - 5'd1;
                  state_in = STEP_FREQ;
               end
            end
         end
         STEP_FREQ: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               rem_in   = {1'b0, dvd_step[15:1]};
               dvd_in   = {dvd_step[0], 16'b0};
               dsr_in   = TICK_RATE;
               cnt_in   = RATE_STEPS - 5'd1;
               state_in = STEP_RATE;
            end
         end
         STEP_RATE: begin
            rem_in = rem_step;
            dvd_in = dvd_step;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = STEP_DONE;
            end
         end
         STEP_DONE: begin
            state_in = STEP_IDLE;
         end
         default: begin
            state_in = STEP_IDLE;
         end
      endcase
   end

   assign step_rsp.busy = state_ff != STEP_IDLE;
   assign step_rsp.done = state_ff == STEP_DONE;
   assign step_rsp.step = dvd_ff;

endmodule

// ----- rtl/core/square_tone_channel_unit.sv -----
// Register write: takes effect when accepted, no result word.
// Tick: its result word is registered at the edge that accepts it.
// A sounding tick keeps the input closed while the serial divider computes the phase
// step one bit per cycle, skipping the frequency division when its quotient clamps.
// Reset is synchronous and clears all channel state.
`include "square_tone_channel_unit_defines.svh"

module square_tone_channel_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // reg_index [2:0], write_value [10:3], zero [15:11]
   input  logic        req_tuser,  // kind [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // sample_value [13:0], zero [15:14]
   output logic        rsp_tuser   // sounding [0]
);
   import sts_pkg::*;

   logic [7:0]  channel_regs_ff [NUM_REGS];
   logic [7:0]  channel_regs_in [NUM_REGS];
   logic [18:0] phase_acc_ff, phase_acc_in;
   logic [3:0]  cur_vol_ff, cur_vol_in;
   logic [13:0] length_time_ff, length_time_in;
   logic [13:0] length_count_ff, length_count_in;
   logic [12:0] env_time_ff, env_time_in;
   logic [12:0] env_count_ff, env_count_in;
   logic [11:0] sweep_period_ff, sweep_period_in;
   logic [11:0] sweep_count_ff, sweep_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [13:0] rsp_sample_ff, rsp_sample_in;
   logic        rsp_sounding_ff, rsp_sounding_in;

   sts_step_req_type step_req;
   sts_step_rsp_type step_rsp;

   logic        accept;
   logic        is_write;
   logic [2:0]  reg_index;
   logic [7:0]  write_value;
   logic [10:0] freq;
   logic [10:0] sweep_delta;
   logic [10:0] swept_freq;
   logic        on;
   logic        tick_on;
   logic [13:0] tone_level;
   logic [13:0] sample;
   logic [13:0] length_next;
   logic [12:0] env_next;
   logic [11:0] sweep_next;

   assign reg_index   = req_tdata[2:0];
   assign write_value = req_tdata[10:3];
   assign is_write    = req_tuser == KIND_WRITE;
   assign req_tready  = !step_rsp.busy && (!rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;

   assign freq        = {channel_regs_ff[REG_FREQ_HI][2:0], channel_regs_ff[REG_FREQ_LO]};
   assign sweep_delta = freq >> channel_regs_ff[REG_SWEEP][2:0];
   assign swept_freq  = channel_regs_ff[REG_SWEEP][3] ? freq - sweep_delta
                                                      : freq + sweep_delta;
   assign on          = length_count_ff < length_time_ff;
   assign tick_on     = accept && !is_write && on;
   assign tone_level  = 14'(AMPLITUDE) * {10'b0, cur_vol_ff};
   assign sample      = (on && duty_bit(channel_regs_ff[REG_LENGTH][7:6], phase_acc_ff[18:16]))
                        ? tone_level : 14'd0;
   assign length_next = length_count_ff + 14'd1;
   assign env_next    = env_count_ff + 13'd1;
   assign sweep_next  = sweep_count_ff + 12'd1;

   assign step_req.start   = tick_on;
   assign step_req.divisor = FREQ_BASE - {1'b0, freq};

   sts_step_unit u_step (
      .clock    (clock),
      .reset    (reset),
      .step_req (step_req),
      .step_rsp (step_rsp)
   );

   always_comb begin
      channel_regs_in = channel_regs_ff;
      phase_acc_in    = phase_acc_ff;
      cur_vol_in      = cur_vol_ff;
      length_time_in  = length_time_ff;
      length_count_in = length_count_ff;
      env_time_in     = env_time_ff;
      env_count_in    = env_count_ff;
      sweep_period_in = sweep_period_ff;
      sweep_count_in  = sweep_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_sample_in   = rsp_sample_ff;
      rsp_sounding_in = rsp_sounding_ff;

      if (step_rsp.done) begin
         phase_acc_in = phase_acc_ff + {2'b0, step_rsp.step};
      end

      if (accept && is_write) begin
         case (reg_index)
            REG_SWEEP: begin
               channel_regs_in[REG_SWEEP] = write_value;
               sweep_period_in = sweep_period_of(write_value[6:4]);
               sweep_count_in  = '0;
            end
            REG_LENGTH: begin
               channel_regs_in[REG_LENGTH] = write_value;
               length_time_in  = length_time_of(write_value[5:0]);
               length_count_in = '0;
            end
            REG_ENVELOPE: begin
               channel_regs_in[REG_ENVELOPE] = write_value;
               env_time_in  = env_time_of(write_value[2:0]);
               env_count_in = '0;
               cur_vol_in   = write_value[7:4];
            end
            REG_FREQ_LO: begin
               channel_regs_in[REG_FREQ_LO] = write_value;
               length_count_in = '0;
            end
            REG_FREQ_HI: begin
               // The restart bit acts once and is never kept.
               channel_regs_in[REG_FREQ_HI] = {1'b0, write_value[6:0]};
               length_count_in = '0;
               if (write_value[7]) begin
                  phase_acc_in   = '0;
                  cur_vol_in     = channel_regs_ff[REG_ENVELOPE][7:4];
                  env_count_in   = '0;
                  sweep_count_in = '0;
               end
            end
            default: begin
            end
         endcase
      end

      if (accept && !is_write) begin
         rsp_valid_in    = 1'b1;
         rsp_sample_in   = sample;
         rsp_sounding_in = on;
      end

      if (tick_on) begin
         length_count_in = length_next;
         if (length_next == length_time_ff && !channel_regs_ff[REG_FREQ_HI][6]) begin
            length_count_in = '0;
         end

         if (env_time_ff != '0) begin
            env_count_in = env_next;
            if (env_next == env_time_ff) begin
               env_count_in = '0;
               if (channel_regs_ff[REG_ENVELOPE][3]) begin
                  if (cur_vol_ff < VOLUME_MAX) begin
                     cur_vol_in = cur_vol_ff + 4'd1;
                  end
               end else if (cur_vol_ff != 4'd0) begin
                  cur_vol_in = cur_vol_ff - 4'd1;
               end
            end
         end

         if (sweep_period_ff != '0) begin
            sweep_count_in = sweep_next;
            if (sweep_next > sweep_period_ff) begin
               sweep_count_in = '0;
               channel_regs_in[REG_FREQ_LO] = swept_freq[7:0];
               channel_regs_in[REG_FREQ_HI] = {channel_regs_ff[REG_FREQ_HI][7:3],
                                               swept_freq[10:8]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            channel_regs_ff[i] <= '0;
         end
         phase_acc_ff    <= '0;
         cur_vol_ff      <= '0;
         length_time_ff  <= '0;
         length_count_ff <= '0;
         env_time_ff     <= '0;
         env_count_ff    <= '0;
         sweep_period_ff <= '0;
         sweep_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         channel_regs_ff <= channel_regs_in;
         phase_acc_ff    <= phase_acc_in;
         cur_vol_ff      <= cur_vol_in;
         length_time_ff  <= length_time_in;
         length_count_ff <= length_count_in;
         env_time_ff     <= env_time_in;
         env_count_ff    <= env_count_in;
         sweep_period_ff <= sweep_period_in;
         sweep_count_ff  <= sweep_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      rsp_sample_ff   <= rsp_sample_in;
      rsp_sounding_ff <= rsp_sounding_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b0, rsp_sample_ff};
   assign rsp_tuser  = rsp_sounding_ff;

   `STS_ASSERT_NOW(a_closed_while_stepping, step_rsp.busy, !req_tready,
      "input accepted while the phase step is being computed")
   `STS_ASSERT_NEXT(a_sounding_tick_starts_step, tick_on, step_rsp.busy,
      "sounding tick did not start the phase step computation")
   `STS_ASSERT_NEXT(a_step_done_once, step_rsp.done, !step_rsp.busy,
      "phase step unit stayed busy after completion")
   `STS_ASSERT_NOW(a_silent_word_is_zero, rsp_valid_ff && !rsp_sounding_ff,
      rsp_sample_ff == 14'd0, "silent word carries a nonzero sample")

endmodule
